// ===== src/kcl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Key click / long-press detector package
// Shared types, state codes, event codes and register reset values.
// ----------------------------------------------------------------------------
package kcl_pkg;

    localparam int TIME_W    = 16;
    localparam int ELAPSED_W = 8;
    localparam int EVENT_W   = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [TIME_W-1:0] DEBOUNCE_RESET = TIME_W'(20);
    localparam logic [TIME_W-1:0] LONG_RESET     = TIME_W'(1000);

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 1'b1;

    localparam logic [EVENT_W-1:0] EV_NONE  = 2'd0;
    localparam logic [EVENT_W-1:0] EV_CLICK = 2'd1;
    localparam logic [EVENT_W-1:0] EV_LONG  = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_HELD     = 2'd2,
        PH_LONG     = 2'd3
    } phase_t;

    typedef struct packed {
        logic [TIME_W-1:0] debounce_time;
        logic [TIME_W-1:0] long_press_time;
    } cfg_t;

endpackage : kcl_pkg
`default_nettype wire

// ===== src/key_click_long_press_detector_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Key click / long-press detector
// Each input beat is one periodic tick carrying the key level and the
// milliseconds since the previous tick; each tick yields exactly one result
// beat with the event it raised (none, click or long press). The block takes
// one tick per clock cycle while the result side is not stalled; each tick
// passes through the input register and then the result register, with the
// state machine update between them. Configuration writes take effect at the
// next clock edge and are meant to be made while no tick is in flight.
// ----------------------------------------------------------------------------
module key_click_long_press_detector_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [kcl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [kcl_pkg::TIME_W-1:0]    cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          pressed,
    input  wire logic [kcl_pkg::ELAPSED_W-1:0] elapsed_ms,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [kcl_pkg::EVENT_W-1:0]        key_event
);
    import kcl_pkg::*;

    cfg_t                 cfg;
    logic                 in_valid_reg;
    logic                 pressed_reg;
    logic [ELAPSED_W-1:0] elapsed_reg;
    logic                 out_valid_reg;
    logic [EVENT_W-1:0]   key_event_reg;
    logic [EVENT_W-1:0]   key_event_next;
    logic                 out_load;
    logic                 step;

    assign out_load = !out_valid_reg || out_ready;
    assign step     = in_valid_reg && out_load;
    assign in_ready = !in_valid_reg || step;

    kcl_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    kcl_fsm u_fsm (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .pressed    (pressed_reg),
        .elapsed_ms (elapsed_reg),
        .cfg        (cfg),
        .key_event  (key_event_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            pressed_reg <= pressed;
            elapsed_reg <= elapsed_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            key_event_reg <= key_event_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign key_event = key_event_reg;

    // A held tick keeps its payload while the result side is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_load |=> in_valid_reg && $stable(pressed_reg)
            && $stable(elapsed_reg))
    else $error("pending tick lost or changed during a stall");

    // Every tick that leaves the input register shows up as a result beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
    else $error("tick consumed without a result beat");

    // The reserved event code is never presented.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (key_event_reg == EV_NONE) || (key_event_reg == EV_CLICK)
            || (key_event_reg == EV_LONG))
    else $error("reserved event code on the result port");

endmodule : key_click_long_press_detector_top
`default_nettype wire

// ===== src/kcl_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Key click / long-press detector configuration registers
// Holds the debounce time and the long-press time, written by index.
// ----------------------------------------------------------------------------
module kcl_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [kcl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [kcl_pkg::TIME_W-1:0]    cfg_data,
    output kcl_pkg::cfg_t                      cfg
);
    import kcl_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_time   <= DEBOUNCE_RESET;
            cfg_reg.long_press_time <= LONG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DEBOUNCE: cfg_reg.debounce_time   <= cfg_data;
                CFG_LONG:     cfg_reg.long_press_time <= cfg_data;
                default:      ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule : kcl_cfg
`default_nettype wire

// ===== src/kcl_fsm.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Key click / long-press detector state machine
// Four-phase press qualifier with a saturating hold counter; one step per beat.
// ----------------------------------------------------------------------------
module kcl_fsm (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          step,
    input  wire logic                          pressed,
    input  wire logic [kcl_pkg::ELAPSED_W-1:0] elapsed_ms,
    input  kcl_pkg::cfg_t                      cfg,
    output logic [kcl_pkg::EVENT_W-1:0]        key_event
);
    import kcl_pkg::*;

    phase_t              phase_reg;
    phase_t              phase_next;
    logic [TIME_W-1:0]   held_ms_reg;
    logic [TIME_W-1:0]   held_ms_next;
    logic [TIME_W:0]     held_sum;
    logic [TIME_W-1:0]   held_sat;

    assign held_sum = {1'b0, held_ms_reg} + {{(TIME_W + 1 - ELAPSED_W){1'b0}}, elapsed_ms};
    assign held_sat = held_sum[TIME_W] ? {TIME_W{1'b1}} : held_sum[TIME_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            held_ms_reg <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            held_ms_reg <= held_ms_next;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        held_ms_next = held_ms_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (pressed)
                begin
                    phase_next   = PH_DEBOUNCE;
                    held_ms_next = '0;
                end
            end
            PH_DEBOUNCE:
            begin
                if (pressed)
                begin
                    if (held_sat >= cfg.debounce_time)
                    begin
                        phase_next   = PH_HELD;
                        held_ms_next = '0;
                    end
                    else
                    begin
                        held_ms_next = held_sat;
                    end
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
            PH_HELD:
            begin
                if (pressed)
                begin
                    held_ms_next = held_sat;
                    if (held_sat >= cfg.long_press_time)
                    begin
                        phase_next = PH_LONG;
                    end
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
            PH_LONG:
            begin
                if (!pressed)
                begin
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_comb
    begin
        key_event = EV_NONE;
        unique case (phase_reg)
            PH_HELD:
            begin
                if (!pressed && (held_ms_reg < cfg.long_press_time))
                begin
                    key_event = EV_CLICK;
                end
                else if (pressed && (held_sat >= cfg.long_press_time))
                begin
                    key_event = EV_LONG;
                end
            end
            default:
            begin
                key_event = EV_NONE;
            end
        endcase
    end

    // A long press always moves the machine into the long-held phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        step && (key_event == EV_LONG) |=> phase_reg == PH_LONG)
    else $error("long press without entering long-held phase");

    // A click always returns the machine to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        step && (key_event == EV_CLICK) |=> phase_reg == PH_IDLE)
    else $error("click without returning to idle");

    // A new press starts debouncing from a cleared counter.
    assert property (@(posedge clk) disable iff (!rst_n)
        step && (phase_reg == PH_IDLE) && pressed
        |=> (phase_reg == PH_DEBOUNCE) && (held_ms_reg == '0))
    else $error("press did not start debounce with a cleared counter");

endmodule : kcl_fsm
`default_nettype wire
